/* rtl/roc_pkg.sv */
package roc_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int VAL_W    = 48;
	localparam int ENTRY_W  = 2 * VAL_W;
	localparam int STATUS_W = 2;
	localparam int MIDX_W   = 6;
	localparam int HELD_W   = 7;

	// request codes
	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_CLEAN   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOROOM  = 2'd2;

	// request payload
	typedef struct packed {
		logic             cmd;
		logic [VAL_W-1:0] range_start;
		logic [VAL_W-1:0] range_length;
	} roc_req_t;

	// result payload
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MIDX_W-1:0]   match_index;
		logic [HELD_W-1:0]   entries_held;
	} roc_res_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd_en;
		logic cmp_en;
		logic insert;
		logic resp_clear;
		logic resp_full;
	} roc_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
		logic last;
		logic hit;
	} roc_stat_t;

	// two ranges overlap on equal starts or when the lower one reaches past the higher start
	function automatic logic ranges_overlap(input logic [VAL_W-1:0] a_start,
		input logic [VAL_W-1:0] a_len, input logic [VAL_W-1:0] b_start,
		input logic [VAL_W-1:0] b_len);
		logic [VAL_W-1:0] lo_start;
		logic [VAL_W-1:0] lo_len;
		logic [VAL_W-1:0] hi_start;
		logic [VAL_W:0]   lo_end;
		if (a_start > b_start) begin
			lo_start = b_start;
			lo_len   = b_len;
			hi_start = a_start;
		end else begin
			lo_start = a_start;
			lo_len   = a_len;
			hi_start = b_start;
		end
		lo_end = {1'b0, lo_start} + {1'b0, lo_len};
		return (a_start == b_start) || (lo_end > {1'b0, hi_start});
	endfunction

endpackage

/* rtl/roc_ram.sv */
module roc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/roc_ctrl.sv */
module roc_ctrl import roc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      req_cmd,
	input  roc_stat_t st,
	output roc_ctl_t  ctl,
	output logic      busy
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ISSUE  = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_INSERT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_cmd == CMD_CLEAR) begin
						ctl.resp_clear = 1'b1;
					end else if (st.full) begin
						ctl.resp_full = 1'b1;
					end else begin
						ctl.load = 1'b1;
						state_d  = st.empty ? S_INSERT : S_ISSUE;
					end
				end
			end
			S_ISSUE: begin
				ctl.rd_en  = 1'b1;
				ctl.cmp_en = 1'b1;
				if (st.hit) begin
					state_d = S_INSERT;
				end else if (st.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				ctl.cmp_en = 1'b1;
				state_d    = S_INSERT;
			end
			S_INSERT: begin
				ctl.insert = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// drain only follows the last read of a scan
	a_drain_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> ($past(state_q) == S_ISSUE && $past(st.last)))
		else $error("drain without a final read");

	// busy only rises on an accepted check request
	a_busy_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(ctl.load))
		else $error("busy rose without a request load");

	// a scan stops at the first hit
	a_hit_stops_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE && st.hit) |=> (state_q == S_INSERT))
		else $error("scan kept going after a hit");

endmodule

/* rtl/roc_dp.sv */
module roc_dp import roc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  roc_req_t  req,
	input  roc_ctl_t  ctl,
	output roc_stat_t st,
	output logic      done,
	output roc_res_t  res
);

	roc_req_t         req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic             hit_q;
	logic [IDX_W-1:0] found_q;
	logic             done_q;
	roc_res_t         res_q;
	logic [ENTRY_W-1:0] rdata;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] cnt_inc;

	assign cnt_dec = cnt_q - CNT_W'(1);
	assign cnt_inc = cnt_q + CNT_W'(1);

	// range table, start and length side by side
	roc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ctl.insert),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata({req_q.range_start, req_q.range_length}),
		.re   (ctl.rd_en),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// status to the controller
	assign st.full  = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign st.last  = (ptr_q == '0);
	assign st.hit   = vld_s1 && ranges_overlap(req_q.range_start, req_q.range_length,
		rdata[ENTRY_W-1:VAL_W], rdata[VAL_W-1:0]);

	// request capture, read pointer and compare results
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q   <= req;
			ptr_q   <= cnt_dec[IDX_W-1:0];
			found_q <= '0;
		end else if (ctl.rd_en) begin
			ptr_q <= ptr_q - IDX_W'(1);
		end
		if (ctl.rd_en) begin
			idx_s1 <= ptr_q;
		end
		if (ctl.cmp_en && st.hit) begin
			found_q <= idx_s1;
		end
		if (ctl.resp_clear) begin
			res_q <= '{status: ST_CLEAN, match_index: '0, entries_held: '0};
		end else if (ctl.resp_full) begin
			res_q <= '{status: ST_NOROOM, match_index: '0, entries_held: '0};
		end else if (ctl.insert) begin
			res_q.status       <= hit_q ? ST_OVERLAP : ST_CLEAN;
			res_q.match_index  <= MIDX_W'(found_q);
			res_q.entries_held <= HELD_W'(cnt_inc);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= ctl.rd_en;
			done_q <= ctl.resp_clear || ctl.resp_full || ctl.insert;
			if (ctl.resp_clear || ctl.resp_full) begin
				cnt_q <= '0;
			end else if (ctl.insert) begin
				cnt_q <= cnt_inc;
			end
			if (ctl.load) begin
				hit_q <= 1'b0;
			end else if (ctl.cmp_en && st.hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

	// the table never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count past table depth");

	// no insert into a full table
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |-> !st.full)
		else $error("insert into a full table");

	// a clear or no-room result leaves an empty table
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.resp_clear || ctl.resp_full) |=> (done && res.entries_held == '0 && st.empty))
		else $error("flush did not empty the table");

endmodule

/* rtl/range_overlap_checklist.sv */
// channel   ports                  handshake
// request   start, busy, req       taken at a rising edge with start high and busy low
// result    done, res              one cycle per result, marked by done, no back-pressure
//
// a check against n stored ranges holds busy through the scan (one table read
// per cycle from the single read port), a drain of the last compare and an
// insert; an early hit cuts the scan short and skips the drain, an empty table goes straight to insert.
// clear and no-room requests are answered without going busy.
// done is registered and rises in the cycle after the request completes; reset empties the table.
// the result side cannot stall: each result is shown once, for one cycle.
module range_overlap_checklist import roc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  roc_req_t req,
	output logic     done,
	output roc_res_t res
);

	roc_ctl_t  ctl;
	roc_stat_t st;

	// sequencer
	roc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req_cmd(req.cmd),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	// table, compare and result registers
	roc_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ctl   (ctl),
		.st    (st),
		.done  (done),
		.res   (res)
	);

endmodule

/* tb/roc_watch.sv */
module roc_watch
	import roc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  roc_req_t req,
	input  logic     done,
	input  roc_res_t res,
	output int       mismatches,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the range table
	logic [VAL_W-1:0] shadow_start [TABLE_DEPTH];
	logic [VAL_W-1:0] shadow_len   [TABLE_DEPTH];
	int               shadow_count;

	// answers still owed by the block, oldest first
	roc_res_t owed_answers [$];
	int       fail_count;

	// print one line per bad field and count it
	task automatic report_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		fail_count++;
		$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// equal starts always meet; otherwise the lower range must end past the higher start
	function automatic logic spans_meet(input logic [VAL_W-1:0] a_s,
		input logic [VAL_W-1:0] a_l, input logic [VAL_W-1:0] b_s,
		input logic [VAL_W-1:0] b_l);
		logic [VAL_W:0] a_end;
		logic [VAL_W:0] b_end;
		a_end = {1'b0, a_s} + {1'b0, a_l};
		b_end = {1'b0, b_s} + {1'b0, b_l};
		if (a_s == b_s)
			return 1'b1;
		if (a_s < b_s)
			return a_end > {1'b0, b_s};
		return b_end > {1'b0, a_s};
	endfunction

	// apply one request to the shadow table and work out the answer
	function automatic roc_res_t predict_answer(input roc_req_t r);
		roc_res_t ans;
		logic     hit;
		int       hit_at;
		int       i;
		ans    = '0;
		hit    = 1'b0;
		hit_at = 0;
		if (r.cmd == CMD_CLEAR) begin
			shadow_count = 0;
			ans.status   = ST_CLEAN;
			return ans;
		end
		if (shadow_count >= TABLE_DEPTH) begin
			shadow_count = 0;
			ans.status   = ST_NOROOM;
			return ans;
		end
		// newest entry first, stop at the first overlap
		for (i = shadow_count - 1; i >= 0 && !hit; i--) begin
			if (spans_meet(r.range_start, r.range_length, shadow_start[i], shadow_len[i])) begin
				hit    = 1'b1;
				hit_at = i;
			end
		end
		shadow_start[shadow_count] = r.range_start;
		shadow_len[shadow_count]   = r.range_length;
		shadow_count++;
		ans.status       = hit ? ST_OVERLAP : ST_CLEAN;
		ans.match_index  = hit_at[MIDX_W-1:0];
		ans.entries_held = shadow_count[HELD_W-1:0];
		return ans;
	endfunction

	// compare finished results first, then log the newly taken request
	always @(posedge clk or negedge arst_n) begin
		roc_res_t want;
		if (!arst_n) begin
			shadow_count = 0;
			fail_count   = 0;
			owed_answers.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				if (owed_answers.size() == 0) begin
					report_mismatch("result with no request owed", 0, 1);
				end else begin
					want = owed_answers.pop_front();
					if (res.status != want.status)
						report_mismatch("status", want.status, res.status);
					if (res.match_index != want.match_index)
						report_mismatch("match_index", want.match_index, res.match_index);
					if (res.entries_held != want.entries_held)
						report_mismatch("entries_held", want.entries_held, res.entries_held);
				end
			end
			if (start && !busy)
				owed_answers.push_back(predict_answer(req));
			mismatches <= fail_count;
			pending    <= owed_answers.size();
		end
	end

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import roc_pkg::*;

	localparam logic [VAL_W-1:0] TOP_VAL = {VAL_W{1'b1}};

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	roc_req_t req;
	logic     done;
	roc_res_t res;
	int       mismatches;
	int       pending;

	range_overlap_checklist u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	roc_watch u_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.res        (res),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic roc_req_t make_request(input logic c, input logic [VAL_W-1:0] s,
		input logic [VAL_W-1:0] l);
		roc_req_t r;
		r.cmd          = c;
		r.range_start  = s;
		r.range_length = l;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] wide_value();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[VAL_W-1:0];
	endfunction

	// mostly small clustered ranges so overlaps are common, plus full-width and top-end values
	function automatic roc_req_t random_request();
		roc_req_t r;
		r.cmd = ($urandom_range(89) == 0) ? CMD_CLEAR : CMD_CHECK;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				r.range_start  = VAL_W'($urandom_range(4095));
				r.range_length = VAL_W'($urandom_range(300));
			end
			6: begin
				r.range_start  = TOP_VAL - VAL_W'($urandom_range(4095));
				r.range_length = $urandom_range(1) ? wide_value() : VAL_W'($urandom_range(8191));
			end
			7: begin
				r.range_start  = VAL_W'($urandom_range(4095));
				r.range_length = wide_value();
			end
			default: begin
				r.range_start  = wide_value();
				r.range_length = wide_value();
			end
		endcase
		return r;
	endfunction

	// hold the request until the block takes it
	task automatic issue(input roc_req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	// random sender gap before the next request
	task automatic sender_gap(input int pct);
		int gap;
		gap = 0;
		while (gap < 100 && $urandom_range(99) < pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int idle_pct [4];
		int ph;
		int n;
		idle_pct = '{0, 83, 0, 15};
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, zero lengths, touching ends, 49-bit sums, clears
		issue(make_request(CMD_CLEAR, '0, '0));
		issue(make_request(CMD_CHECK, '0, '0));
		issue(make_request(CMD_CHECK, '0, '0));
		issue(make_request(CMD_CHECK, TOP_VAL, TOP_VAL));
		issue(make_request(CMD_CHECK, TOP_VAL, '0));
		issue(make_request(CMD_CHECK, 48'd100, '0));
		issue(make_request(CMD_CHECK, 48'd50, 48'd51));
		issue(make_request(CMD_CHECK, 48'd101, 48'd5));
		issue(make_request(CMD_CHECK, TOP_VAL - 48'd1, 48'd1));
		issue(make_request(CMD_CHECK, TOP_VAL - 48'd1, 48'd2));
		issue(make_request(CMD_CHECK, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555));
		issue(make_request(CMD_CHECK, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA));
		issue(make_request(CMD_CLEAR, TOP_VAL, TOP_VAL));
		issue(make_request(CMD_CHECK, 48'd7, 48'd3));
		issue(make_request(CMD_CLEAR, '0, '0));

		// random requests over several idling phases
		for (ph = 0; ph < 4; ph++) begin
			for (n = 0; n < 300; n++) begin
				sender_gap(idle_pct[ph]);
				issue(random_request());
			end
		end
		start <= 1'b0;

		// drain outstanding results
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
